[design/dttu_pkg.sv]
// Package for the decimal text to u64 parser.
// Holds the widths, character codes and value type used by the top level; no dependencies.
package dttu_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DigitW = 4;
  localparam int unsigned ValueW = 64;

  localparam logic [ByteW-1:0]  CharZero    = 8'h30;  // '0'
  localparam logic [ByteW-1:0]  CharNine    = 8'h39;  // '9'
  localparam logic [ByteW-1:0]  CharNewline = 8'h0A;  // '\n'

  typedef logic [ValueW-1:0] value_t;

endpackage : dttu_pkg

[design/decimal_text_to_u64_parser_top.sv]
// Streaming decimal text to unsigned 64-bit parser, top level.
// Depends on dttu_pkg for character codes and the value type.

// One byte of a text record is taken per item, the final byte marked by
// end_of_record_i. Each byte is folded into the record state in the cycle it
// is accepted: the running value is multiplied by ten (shift-and-add) and the
// digit added, with a 68-bit sum whose upper nibble flags a 64-bit overflow.
// The marked byte produces one result item in the result register in the next
// cycle: number_ok_o set only for a record of at most MAX_RECORD_BYTES
// bytes, 1..MAX_DIGITS digits, no non-digit other than a single trailing
// newline, no overflow and a nonzero value; number_value_o is zero otherwise.
// The block takes one byte every cycle while it does not stall. Unmarked bytes are taken even while a
// result waits to be collected; only a marked byte stalls, and only when the
// result register is full and the far side is stalling. The record state is
// cleared after every marked byte, accepted or rejected.
module decimal_text_to_u64_parser_top
  import dttu_pkg::*;
#(
  parameter int unsigned MAX_RECORD_BYTES = 32,
  parameter int unsigned MAX_DIGITS       = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             end_of_record_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             number_ok_o,
  output value_t           number_value_o
);

  // Counters saturate at limit plus one, so they must hold that value.
  localparam int unsigned BytCntW = $clog2(MAX_RECORD_BYTES + 2);
  localparam int unsigned DigCntW = $clog2(MAX_DIGITS + 2);
  localparam logic [BytCntW-1:0] ByteLimit  = BytCntW'(MAX_RECORD_BYTES);
  localparam logic [DigCntW-1:0] DigitLimit = DigCntW'(MAX_DIGITS);

  // Record state
  value_t             running_value_q, running_value_d;
  logic [BytCntW-1:0] byte_count_q, byte_count_d;
  logic [DigCntW-1:0] digit_count_q, digit_count_d;
  logic               record_bad_q, record_bad_d;

  // Result register
  logic   out_valid_q, out_valid_d;
  logic   number_ok_q, number_ok_d;
  value_t number_value_q, number_value_d;

  logic                      in_accept, out_take;
  logic                      is_digit, trailing_nl;
  logic [DigitW-1:0]         digit;
  logic [ValueW+DigitW-1:0]  times_ten;
  logic                      overflow;
  logic                      record_ok;

  // Take a result when the far side is not stalling; a marked byte needs a
  // free (or freeing) result slot, unmarked bytes never wait.
  assign out_take   = out_valid_q & ~out_stall_i;
  assign in_stall_o = end_of_record_i & out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    is_digit    = (text_byte_i >= CharZero) && (text_byte_i <= CharNine);
    trailing_nl = end_of_record_i && (text_byte_i == CharNewline);
    digit       = DigitW'(text_byte_i - CharZero);

    // v*10 + d = (v << 3) + (v << 1) + d, kept 4 bits wider to see the carry.
    times_ten = ({{DigitW{1'b0}}, running_value_q} << 3)
              + ({{DigitW{1'b0}}, running_value_q} << 1)
              + {{ValueW{1'b0}}, digit};
    overflow  = |times_ten[ValueW+DigitW-1:ValueW];

    running_value_d = running_value_q;
    byte_count_d    = byte_count_q;
    digit_count_d   = digit_count_q;
    record_bad_d    = record_bad_q;

    if (byte_count_q <= ByteLimit) begin
      byte_count_d = byte_count_q + BytCntW'(1);
    end

    if (is_digit) begin
      if (digit_count_q <= DigitLimit) begin
        digit_count_d = digit_count_q + DigCntW'(1);
      end
      if (!record_bad_q) begin
        if (overflow) begin
          record_bad_d = 1'b1;
        end else begin
          running_value_d = times_ten[ValueW-1:0];
        end
      end
    end else if (!trailing_nl) begin
      record_bad_d = 1'b1;
    end

    // Judge the record on its state after this byte.
    record_ok = !record_bad_d
             && (byte_count_d <= ByteLimit)
             && (digit_count_d != '0)
             && (digit_count_d <= DigitLimit)
             && (running_value_d != '0);

    // Result register: drop a taken result, load on a marked byte.
    out_valid_d    = out_valid_q & ~out_take;
    number_ok_d    = number_ok_q;
    number_value_d = number_value_q;
    if (in_accept && end_of_record_i) begin
      out_valid_d    = 1'b1;
      number_ok_d    = record_ok;
      number_value_d = record_ok ? running_value_d : '0;
      // Clear the record state for the next record.
      running_value_d = '0;
      byte_count_d    = '0;
      digit_count_d   = '0;
      record_bad_d    = 1'b0;
    end
  end

  // Record state advances only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_value_q <= '0;
      byte_count_q    <= '0;
      digit_count_q   <= '0;
      record_bad_q    <= 1'b0;
    end else if (in_accept) begin
      running_value_q <= running_value_d;
      byte_count_q    <= byte_count_d;
      digit_count_q   <= digit_count_d;
      record_bad_q    <= record_bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the result register needs no reset.
  always_ff @(posedge clk_i) begin
    number_ok_q    <= number_ok_d;
    number_value_q <= number_value_d;
  end

  assign out_valid_o    = out_valid_q;
  assign number_ok_o    = number_ok_q;
  assign number_value_o = number_value_q;

  // A marked byte that is taken always shows up as a result next cycle.
  a_result_follows_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_record_i |=> out_valid_o)
    else $error("marked byte accepted but no result presented");

  // The record state is back at reset after every marked byte.
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_record_i |=>
      running_value_q == '0 && byte_count_q == '0 && digit_count_q == '0 && !record_bad_q)
    else $error("record state not cleared after marked byte");

  // A rejected record reports zero; an accepted one a nonzero value.
  a_value_matches_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (number_ok_o == (number_value_o != '0)))
    else $error("result value disagrees with its ok flag");

endmodule : decimal_text_to_u64_parser_top

[tb/testbench.sv]
// Self-checking testbench for decimal_text_to_u64_parser_top.
// Depends on dttu_pkg and the parser RTL; drives byte records and checks each
// result item against an in-bench model of the record parser.
module testbench;
  import dttu_pkg::*;

  localparam int unsigned MaxRecordBytes = 32;
  localparam int unsigned MaxDigits      = 20;
  localparam int unsigned StimBytes      = 1780;
  localparam int unsigned SettleCycles   = 16;
  localparam int unsigned CycleLimit     = 400000;
  localparam value_t      ValueMax       = '1;

  // One byte of a record with the idle cycles that precede it.
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             last;
    logic [3:0]       gap;
  } text_item_t;

  // What one marked byte should produce.
  typedef struct packed {
    logic   ok;
    value_t value;
  } number_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] text_byte_i     = '0;
  logic             end_of_record_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i     = 1'b0;
  logic             number_ok_o;
  value_t           number_value_o;

  text_item_t       pending_bytes[$];
  number_t          awaited_numbers[$];
  logic [ByteW-1:0] text_buf[$];

  // Record state of the model, cleared after every marked byte.
  value_t      rec_value;
  int unsigned rec_bytes;
  int unsigned rec_digits;
  bit          rec_bad;

  bit          burst_record;
  bit          byte_in_flight;
  int unsigned error_count;
  int unsigned cycle_count;

  decimal_text_to_u64_parser_top #(
    .MAX_RECORD_BYTES(MaxRecordBytes),
    .MAX_DIGITS      (MaxDigits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_record_i(end_of_record_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .number_ok_o    (number_ok_o),
    .number_value_o (number_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Fold one accepted byte into the record state. Return 1 and the parsed
  // number when the byte closes the record, then clear the state.
  function automatic bit fold_text_byte(input logic [ByteW-1:0] ch, input logic last,
                                        output number_t num);
    value_t digit;
    bit     accept;
    num = '0;
    // Count bytes and digits, saturating one past their limits.
    if (rec_bytes <= MaxRecordBytes) rec_bytes++;
    if (ch >= CharZero && ch <= CharNine) begin
      digit = value_t'(ch - CharZero);
      if (rec_digits <= MaxDigits) rec_digits++;
      // Freeze the value once the next digit would carry past 64 bits.
      if (!rec_bad) begin
        if (rec_value > (ValueMax - digit) / 64'd10) rec_bad = 1'b1;
        else rec_value = rec_value * 64'd10 + digit;
      end
    end else if (!(last && ch == CharNewline)) begin
      // Any non-digit spoils the record, bar a newline as the marked byte.
      rec_bad = 1'b1;
    end
    if (!last) return 1'b0;
    accept = !rec_bad && rec_bytes <= MaxRecordBytes && rec_digits >= 1 &&
             rec_digits <= MaxDigits && rec_value != '0;
    num.ok    = accept;
    num.value = accept ? rec_value : '0;
    rec_value  = '0;
    rec_bytes  = 0;
    rec_digits = 0;
    rec_bad    = 1'b0;
    return 1'b1;
  endfunction

  // Driver: present queued bytes, each after its own idle gap, and hold the
  // payload steady while the parser stalls.
  text_item_t  staged;
  bit          showing;
  int unsigned gap_left;
  number_t     parsed;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      text_byte_i     <= '0;
      end_of_record_i <= 1'b0;
      showing         = 1'b0;
      byte_in_flight  = 1'b0;
      gap_left        = 0;
      rec_value       = '0;
      rec_bytes       = 0;
      rec_digits      = 0;
      rec_bad         = 1'b0;
    end else begin
      // Take the handshake and predict what the byte causes.
      if (in_valid_i && !in_stall_o) begin
        if (fold_text_byte(text_byte_i, end_of_record_i, parsed))
          awaited_numbers.push_back(parsed);
        showing        = 1'b0;
        byte_in_flight = 1'b0;
      end
      // Fetch the next byte and its gap.
      if (!byte_in_flight && pending_bytes.size() != 0) begin
        staged         = pending_bytes.pop_front();
        byte_in_flight = 1'b1;
        gap_left       = 32'(staged.gap);
      end
      // Idle out the gap, then raise valid with the payload.
      if (byte_in_flight && !showing) begin
        if (gap_left == 0) begin
          showing = 1'b1;
          text_byte_i     <= staged.ch;
          end_of_record_i <= staged.last;
        end else begin
          gap_left--;
        end
      end
      in_valid_i <= showing;
    end
  end

  // Monitor: stall each result item for a drawn number of cycles, then check
  // it against the oldest awaited number.
  int unsigned stall_left;
  int unsigned results_seen;
  number_t     want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      stall_left   = 0;
      results_seen = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_numbers.size() == 0) begin
          $error("unexpected result: number_ok %0b number_value %0d", number_ok_o,
                 number_value_o);
          error_count++;
        end else begin
          want = awaited_numbers.pop_front();
          if (number_ok_o !== want.ok) begin
            $error("number_ok: expected %0b, actual %0b", want.ok, number_ok_o);
            error_count++;
          end
          if (number_value_o !== want.value) begin
            $error("number_value: expected %0d, actual %0d", want.value, number_value_o);
            error_count++;
          end
        end
        results_seen++;
        // Leave every fourth stretch of ten results unstalled.
        stall_left = ((results_seen % 40) < 10) ? 0 : $urandom_range(0, 15);
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Record builders: append to text_buf, then flush it as one record.
  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic put_digits(input int unsigned n, input bit lead_nonzero);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0 && lead_nonzero) text_buf.push_back(ByteW'(CharZero + $urandom_range(1, 9)));
      else text_buf.push_back(ByteW'(CharZero + $urandom_range(0, 9)));
    end
  endtask

  task automatic put_non_digit();
    logic [ByteW-1:0] b;
    b = CharZero;
    while (b >= CharZero && b <= CharNine) b = ByteW'($urandom_range(0, 255));
    text_buf.push_back(b);
  endtask

  task automatic maybe_newline();
    if ($urandom_range(0, 1) != 0) text_buf.push_back(CharNewline);
  endtask

  task automatic flush_record();
    text_item_t item;
    for (int i = 0; i < text_buf.size(); i++) begin
      item.ch   = text_buf[i];
      item.last = (i == text_buf.size() - 1);
      item.gap  = burst_record ? 4'd0 : 4'($urandom_range(0, 15));
      pending_bytes.push_back(item);
    end
    text_buf.delete();
  endtask

  task automatic random_record();
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    kind         = $urandom_range(0, 99);
    burst_record = ($urandom_range(0, 3) == 0);
    if (kind < 40) begin
      // Plain number, from one digit up to twenty, sometimes past 64 bits.
      put_digits($urandom_range(1, MaxDigits), 1'b1);
      maybe_newline();
    end else if (kind < 50) begin
      // Close to the top of the range: probe the overflow edge.
      put_text("1844674407370955161");
      if ($urandom_range(0, 9) < 7) put_digits(1, 1'b0);
      maybe_newline();
    end else if (kind < 58) begin
      // Leading zeros: push digit and byte counts past their limits.
      put_digits(0, 1'b0);
      n = $urandom_range(0, 30);
      for (int unsigned i = 0; i < n; i++) text_buf.push_back(CharZero);
      put_digits($urandom_range(1, 12), 1'b1);
      maybe_newline();
    end else if (kind < 63) begin
      // Value zero.
      n = $urandom_range(1, 5);
      for (int unsigned i = 0; i < n; i++) text_buf.push_back(CharZero);
      maybe_newline();
    end else if (kind < 68) begin
      // Newline inside the record, followed by digits or by a second newline.
      put_digits($urandom_range(0, 5), 1'b1);
      text_buf.push_back(CharNewline);
      if ($urandom_range(0, 1) != 0) put_digits($urandom_range(1, 3), 1'b0);
      else text_buf.push_back(CharNewline);
    end else if (kind < 75) begin
      // Long run of bytes around the record length limit.
      n = $urandom_range(MaxRecordBytes - 3, MaxRecordBytes + 8);
      for (int unsigned i = 1; i < n; i++) text_buf.push_back(CharZero);
      text_buf.push_back(ByteW'(CharZero + $urandom_range(1, 9)));
      maybe_newline();
    end else if (kind < 85) begin
      // Well-formed number with one foreign byte dropped in.
      put_digits($urandom_range(1, 10), 1'b1);
      pos = $urandom_range(0, text_buf.size());
      put_non_digit();
      text_buf.insert(pos, text_buf.pop_back());
      maybe_newline();
    end else begin
      // Noise: any byte values.
      n = $urandom_range(1, 6);
      for (int unsigned i = 0; i < n; i++) text_buf.push_back(ByteW'($urandom_range(0, 255)));
    end
    flush_record();
  endtask

  initial begin
    error_count  = 0;
    cycle_count  = 0;
    burst_record = 1'b1;
    // Directed records: lone newline, zero, trailing newline, newline before
    // the end, extreme byte values, a single digit and the largest value.
    put_text("\n");
    flush_record();
    put_text("0");
    flush_record();
    put_text("7\n");
    flush_record();
    put_text("5\n3");
    flush_record();
    text_buf.push_back(8'hFF);
    flush_record();
    text_buf.push_back(8'h00);
    flush_record();
    put_text("9");
    flush_record();
    put_text("18446744073709551615");
    flush_record();
    while (pending_bytes.size() < StimBytes) random_record();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every byte taken and every result checked.
    while (pending_bytes.size() != 0 || byte_in_flight || awaited_numbers.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : testbench

[sim.f]
design/dttu_pkg.sv
design/decimal_text_to_u64_parser_top.sv
tb/testbench.sv
